// ===== rtl/core/btc_pkg.sv =====
// btc_pkg: shared types and constants for the barometric compensation block.
// Used by btc_front, btc_fifo, btc_back and baro_temp_compensation.
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

    // register indexes on the configuration port (byte address = 8 * index)
    localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] REG_PRESS_MID   = 2'd2;
    localparam logic [1:0] REG_PRESS_HIGH  = 2'd3;

    localparam int ADC_W   = 20;
    localparam int TEMP_W  = 32;
    localparam int PRESS_W = 32;
    localparam int DIV_W   = 31;   // divisor magnitude, at most 2^30
    localparam int NUM_W   = 64;

    // calibration words unpacked from the registers
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    // one word handed from the front end to the divider back end
    typedef struct packed {
        logic [NUM_W-1:0]  un;    // numerator magnitude
        logic [DIV_W-1:0]  ud;    // divisor magnitude (1 when divisor is zero)
        logic              neg;   // quotient sign
        logic              ok;    // divisor nonzero
        logic [TEMP_W-1:0] tc;    // temperature, 0.01 degC
    } div_job_t;

    // one divider stage
    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;    // numerator bits out at the top, quotient in at the bottom
        logic [DIV_W-1:0]  ud;
        logic              neg;
        logic              ok;
        logic [TEMP_W-1:0] tc;
    } div_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/btc_front.sv =====
// btc_front: temperature compensation and pressure numerator/divisor pipeline.
// Depends on btc_pkg. Eleven stages, all advancing on one enable.
`timescale 1ns / 1ps
`default_nettype none

module btc_front
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire btc_pkg::calib_t         cal,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [19:0]             adc_temp,
    input  wire logic [19:0]             adc_press,
    output logic                         job_valid,
    output btc_pkg::div_job_t            job,
    input  wire logic                    job_full
);

    localparam int NSTG = 11;

    logic [NSTG-1:0] vld_reg;
    logic            en;

    // stage 1
    logic signed [18:0] a_c;
    logic signed [16:0] dt_c;
    logic signed [34:0] s1_ta_reg;
    logic signed [33:0] s1_dd_reg;
    // stage 2
    logic signed [23:0] s2_ta_reg;
    logic signed [37:0] s2_tb_reg;
    // stage 3
    logic signed [24:0] s3_fine_reg;
    // stage 4
    logic signed [27:0] f5_c;
    logic signed [25:0] x_c;
    logic        [31:0] s4_tc_reg;
    logic signed [51:0] s4_xx_reg;
    logic signed [41:0] s4_xp5_reg;
    logic signed [41:0] s4_xp2_reg;
    // stage 5
    logic signed [48:0] s5_l6_reg;
    logic signed [35:0] s5_h6_reg;
    logic signed [48:0] s5_l3_reg;
    logic signed [35:0] s5_h3_reg;
    logic signed [41:0] s5_xp5_reg;
    logic signed [41:0] s5_xp2_reg;
    logic        [31:0] s5_tc_reg;
    // stage 6
    logic [63:0] s6_xxp6_reg;
    logic [63:0] s6_xxp3_reg;
    logic signed [41:0] s6_xp5_reg;
    logic signed [41:0] s6_xp2_reg;
    logic        [31:0] s6_tc_reg;
    // stage 7
    logic [63:0] s7_y_reg;
    logic [63:0] s7_x2b_reg;
    logic [31:0] s7_tc_reg;
    // stage 8
    logic [20:0] pp_c;
    logic [63:0] s8_nm_reg;
    logic [47:0] s8_lo1_reg;
    logic [47:0] s8_hi1_reg;
    logic [31:0] s8_tc_reg;
    // stage 9
    logic [63:0] prod1_c;
    logic [30:0] s9_d_reg;
    logic [43:0] s9_lon_reg;
    logic [43:0] s9_hin_reg;
    logic [31:0] s9_tc_reg;
    // stage 10
    logic [63:0] s10_num_reg;
    logic [30:0] s10_d_reg;
    logic [31:0] s10_tc_reg;
    // stage 11
    btc_pkg::div_job_t s11_job_reg;

    // raw code of the pressure travels alongside until stage 8
    logic [19:0] ap_reg [0:6];

    assign en        = !vld_reg[NSTG-1] || !job_full;
    assign in_ready  = en;
    assign job_valid = vld_reg[NSTG-1];
    assign job       = s11_job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_comb
    begin
        a_c   = $signed({2'b00, adc_temp[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
        dt_c  = $signed({1'b0, adc_temp[19:4]}) - $signed({1'b0, cal.t1});
        f5_c  = $signed({{3{s3_fine_reg[24]}}, s3_fine_reg}) * 28'sd5 + 28'sd128;
        x_c   = $signed({s3_fine_reg[24], s3_fine_reg}) - 26'sd128000;
        pp_c  = 21'h100000 - {1'b0, ap_reg[6]};
        prod1_c = {16'h0000, s8_lo1_reg} + {s8_hi1_reg[31:0], 32'h0000_0000};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // temperature
            s1_ta_reg   <= a_c * cal.t2;
            s1_dd_reg   <= dt_c * dt_c;
            ap_reg[0]   <= adc_press;
            for (int i = 1; i < 7; i++)
            begin
                ap_reg[i] <= ap_reg[i-1];
            end
            s2_ta_reg   <= s1_ta_reg[34:11];
            s2_tb_reg   <= $signed(s1_dd_reg[33:12]) * cal.t3;
            s3_fine_reg <= $signed({s2_ta_reg[23], s2_ta_reg})
                         + $signed({s2_tb_reg[37], s2_tb_reg[37:14]});
            // fine temperature to centi-degrees and pressure terms
            s4_tc_reg   <= {{12{f5_c[27]}}, f5_c[27:8]};
            s4_xx_reg   <= x_c * x_c;
            s4_xp5_reg  <= x_c * cal.p5;
            s4_xp2_reg  <= x_c * cal.p2;
            // x^2 times P6 / P3 split in 32-bit halves
            s5_l6_reg   <= $signed({1'b0, s4_xx_reg[31:0]}) * cal.p6;
            s5_h6_reg   <= $signed(s4_xx_reg[51:32]) * cal.p6;
            s5_l3_reg   <= $signed({1'b0, s4_xx_reg[31:0]}) * cal.p3;
            s5_h3_reg   <= $signed(s4_xx_reg[51:32]) * cal.p3;
            s5_xp5_reg  <= s4_xp5_reg;
            s5_xp2_reg  <= s4_xp2_reg;
            s5_tc_reg   <= s4_tc_reg;
            s6_xxp6_reg <= {{15{s5_l6_reg[48]}}, s5_l6_reg} + {s5_h6_reg[31:0], 32'h0};
            s6_xxp3_reg <= {{15{s5_l3_reg[48]}}, s5_l3_reg} + {s5_h3_reg[31:0], 32'h0};
            s6_xp5_reg  <= s5_xp5_reg;
            s6_xp2_reg  <= s5_xp2_reg;
            s6_tc_reg   <= s5_tc_reg;
            // y and the divisor pre-term, all modulo 2^64
            s7_y_reg    <= s6_xxp6_reg
                         + ({{22{s6_xp5_reg[41]}}, s6_xp5_reg} << 17)
                         + ({{48{cal.p4[15]}}, cal.p4} << 35);
            s7_x2b_reg  <= {{8{s6_xxp3_reg[63]}}, s6_xxp3_reg[63:8]}
                         + ({{22{s6_xp2_reg[41]}}, s6_xp2_reg} << 12)
                         + 64'h0000_8000_0000_0000;
            s7_tc_reg   <= s6_tc_reg;
            s8_nm_reg   <= {12'h000, pp_c, 31'h0} - s7_y_reg;
            s8_lo1_reg  <= s7_x2b_reg[31:0] * cal.p1;
            s8_hi1_reg  <= s7_x2b_reg[63:32] * cal.p1;
            s8_tc_reg   <= s7_tc_reg;
            // divisor is bits [63:33] of the product
            s9_d_reg    <= prod1_c[63:33];
            s9_lon_reg  <= s8_nm_reg[31:0] * 12'd3125;
            s9_hin_reg  <= s8_nm_reg[63:32] * 12'd3125;
            s9_tc_reg   <= s8_tc_reg;
            s10_num_reg <= {20'h00000, s9_lon_reg} + {s9_hin_reg[31:0], 32'h0};
            s10_d_reg   <= s9_d_reg;
            s10_tc_reg  <= s9_tc_reg;
            // sign/magnitude for the unsigned divider
            s11_job_reg.neg <= s10_num_reg[63] ^ s10_d_reg[30];
            s11_job_reg.un  <= s10_num_reg[63] ? (64'h0 - s10_num_reg) : s10_num_reg;
            s11_job_reg.ok  <= (s10_d_reg != 31'h0);
            s11_job_reg.ud  <= (s10_d_reg == 31'h0) ? 31'h1 :
                               (s10_d_reg[30] ? (31'h0 - s10_d_reg) : s10_d_reg);
            s11_job_reg.tc  <= s10_tc_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/btc_fifo.sv =====
// btc_fifo: short queue of divider jobs between front and back end.
// Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btc_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire btc_pkg::div_job_t wr_data,
    output logic                   full,
    input  wire logic              pop,
    output btc_pkg::div_job_t      rd_data,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    btc_pkg::div_job_t mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/btc_back.sv =====
// btc_back: pipelined radix-2 divider and pressure correction terms.
// Depends on btc_pkg. 64 divider stages then seven post stages, last one is the output.
`timescale 1ns / 1ps
`default_nettype none

module btc_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire btc_pkg::calib_t   cal,
    input  wire logic              job_avail,
    input  wire btc_pkg::div_job_t job,
    output logic                   job_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            temp_centi,
    output logic [31:0]            press_q24_8,
    output logic                   press_valid
);

    localparam int STEPS = btc_pkg::NUM_W;
    localparam int NPOST = 7;

    logic en;

    btc_pkg::div_stage_t src [0:STEPS-1];
    btc_pkg::div_stage_t stg_reg [0:STEPS-1];
    logic [STEPS-1:0] dvld_reg;
    logic [NPOST-1:0] pvld_reg;

    // post stages
    logic [63:0] qn_c;
    logic [63:0] sv_c;
    logic [63:0] p1_q_reg;
    logic        p1_ok_reg;
    logic [31:0] p1_tc_reg;
    logic [63:0] p2_ll_reg;
    logic [63:0] p2_cr_reg;
    logic signed [48:0] p2_l8_reg;
    logic signed [47:0] p2_h8_reg;
    logic [39:0] p2_q_reg;
    logic        p2_ok_reg;
    logic [31:0] p2_tc_reg;
    logic [63:0] p3_ss_reg;
    logic [63:0] p3_qp8_c;
    logic [39:0] p3_v_reg;
    logic [39:0] p3_q_reg;
    logic        p3_ok_reg;
    logic [31:0] p3_tc_reg;
    logic signed [48:0] p4_l9_reg;
    logic signed [47:0] p4_h9_reg;
    logic [39:0] p4_v_reg;
    logic [39:0] p4_q_reg;
    logic        p4_ok_reg;
    logic [31:0] p4_tc_reg;
    logic [63:0] ssp9_c;
    logic [39:0] p5_u_reg;
    logic [39:0] p5_v_reg;
    logic [39:0] p5_q_reg;
    logic        p5_ok_reg;
    logic [31:0] p5_tc_reg;
    logic [39:0] p6_sum_reg;
    logic        p6_ok_reg;
    logic [31:0] p6_tc_reg;
    logic [31:0] pq_c;
    logic [31:0] out_pq_reg;
    logic        out_ok_reg;
    logic [31:0] out_tc_reg;

    function automatic btc_pkg::div_stage_t div_step(input btc_pkg::div_stage_t s);
        btc_pkg::div_stage_t r;
        logic [31:0] t;
        logic [31:0] d;
        r = s;
        t = {s.rem, s.nq[63]};
        d = {1'b0, s.ud};
        if (t >= d)
        begin
            t = t - d;
            r.nq = {s.nq[62:0], 1'b1};
        end
        else
        begin
            r.nq = {s.nq[62:0], 1'b0};
        end
        r.rem = t[30:0];
        return r;
    endfunction

    assign en          = !pvld_reg[NPOST-1] || out_ready;
    assign job_pop     = job_avail && en;
    assign out_valid   = pvld_reg[NPOST-1];
    assign temp_centi  = out_tc_reg;
    assign press_q24_8 = out_pq_reg;
    assign press_valid = out_ok_reg;

    always_comb
    begin
        src[0].rem = '0;
        src[0].nq  = job.un;
        src[0].ud  = job.ud;
        src[0].neg = job.neg;
        src[0].ok  = job.ok;
        src[0].tc  = job.tc;
        for (int i = 1; i < STEPS; i++)
        begin
            src[i] = stg_reg[i-1];
        end
        qn_c     = stg_reg[STEPS-1].neg ? (64'h0 - stg_reg[STEPS-1].nq) : stg_reg[STEPS-1].nq;
        sv_c     = {{13{p1_q_reg[63]}}, p1_q_reg[63:13]};
        p3_qp8_c = {{15{p2_l8_reg[48]}}, p2_l8_reg} + {p2_h8_reg[31:0], 32'h0};
        ssp9_c   = {{15{p4_l9_reg[48]}}, p4_l9_reg} + {p4_h9_reg[31:0], 32'h0};
        pq_c     = p6_sum_reg[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'h0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
            pvld_reg <= '0;
        end
        else if (en)
        begin
            dvld_reg <= {dvld_reg[STEPS-2:0], job_pop};
            pvld_reg <= {pvld_reg[NPOST-2:0], dvld_reg[STEPS-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                stg_reg[i] <= div_step(src[i]);
            end
            // signed quotient
            p1_q_reg  <= qn_c;
            p1_ok_reg <= stg_reg[STEPS-1].ok;
            p1_tc_reg <= stg_reg[STEPS-1].tc;
            // (q>>13)^2 and q*P8 as 32-bit partial products
            p2_ll_reg <= sv_c[31:0] * sv_c[31:0];
            p2_cr_reg <= sv_c[31:0] * sv_c[63:32];
            p2_l8_reg <= $signed({1'b0, p1_q_reg[31:0]}) * cal.p8;
            p2_h8_reg <= $signed(p1_q_reg[63:32]) * cal.p8;
            p2_q_reg  <= p1_q_reg[39:0];
            p2_ok_reg <= p1_ok_reg;
            p2_tc_reg <= p1_tc_reg;
            p3_ss_reg <= p2_ll_reg + {p2_cr_reg[30:0], 1'b0, 32'h0};
            p3_v_reg  <= p3_qp8_c[58:19];
            p3_q_reg  <= p2_q_reg;
            p3_ok_reg <= p2_ok_reg;
            p3_tc_reg <= p2_tc_reg;
            p4_l9_reg <= $signed({1'b0, p3_ss_reg[31:0]}) * cal.p9;
            p4_h9_reg <= $signed(p3_ss_reg[63:32]) * cal.p9;
            p4_v_reg  <= p3_v_reg;
            p4_q_reg  <= p3_q_reg;
            p4_ok_reg <= p3_ok_reg;
            p4_tc_reg <= p3_tc_reg;
            p5_u_reg  <= {ssp9_c[63], ssp9_c[63:25]};
            p5_v_reg  <= p4_v_reg;
            p5_q_reg  <= p4_q_reg;
            p5_ok_reg <= p4_ok_reg;
            p5_tc_reg <= p4_tc_reg;
            p6_sum_reg <= p5_q_reg + p5_u_reg + p5_v_reg;
            p6_ok_reg  <= p5_ok_reg;
            p6_tc_reg  <= p5_tc_reg;
            out_pq_reg <= p6_ok_reg ? pq_c : 32'h0;
            out_ok_reg <= p6_ok_reg;
            out_tc_reg <= p6_tc_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/baro_temp_compensation.sv =====
// baro_temp_compensation: top level, configuration registers and stream ports.
// Depends on btc_pkg, btc_front, btc_fifo, btc_back.
//
// Usage:
//  - Input stream s_*: one word per sample pair, s_tdata = adc_temp then adc_press.
//  - Output stream m_*: one word per input word, same order. m_tdata holds
//    temp_centi (0.01 degC, signed) and press_q24_8 (Pa, unsigned Q24.8);
//    m_tuser is press_valid, low when the pressure divisor came out zero
//    (pressure then reads 0, temperature is still valid).
//  - APB port: four calibration registers at byte addresses 0, 8, 16, 24
//    (temp_calib, press_calib_low, press_calib_mid, press_calib_high).
//    Write them only while no words are in flight.
//  - Throughput: one word per cycle, sustained while m_tready stays high.
//  - Path: the word crosses 83 registers: 11 front stages (temperature and
//    divisor/numerator), one slot in the job queue, 64 divider stages (one
//    quotient bit each) and 7 correction stages; the accepting edge itself
//    loads the first of them.
//  - Reset clears all pipeline valid bits, the queue and the registers to 0.
//  - When m_tready is low and a word waits at the output the back end holds; the front end keeps taking
//    words until its output stage and the queue are full, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_compensation
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // [19:0] adc_temp, [39:20] adc_press
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [31:0] temp_centi, [63:32] press_q24_8
    output logic [0:0]       m_tuser,    // [0] press_valid
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_mid_reg;
    logic [15:0] press_high_reg;

    logic [1:0]  reg_idx;
    logic        wr_en;

    btc_pkg::calib_t   cal;
    btc_pkg::div_job_t fr_job;
    btc_pkg::div_job_t q_job;
    logic              fr_valid;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              q_push;
    logic [31:0]       temp_centi;
    logic [31:0]       press_q24_8;
    logic              press_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_mid_reg  <= '0;
            press_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                btc_pkg::REG_TEMP_CALIB: temp_calib_reg <= pwdata[47:0];
                btc_pkg::REG_PRESS_LOW:  press_low_reg  <= pwdata;
                btc_pkg::REG_PRESS_MID:  press_mid_reg  <= pwdata;
                btc_pkg::REG_PRESS_HIGH: press_high_reg <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            btc_pkg::REG_TEMP_CALIB: prdata = {16'h0000, temp_calib_reg};
            btc_pkg::REG_PRESS_LOW:  prdata = press_low_reg;
            btc_pkg::REG_PRESS_MID:  prdata = press_mid_reg;
            btc_pkg::REG_PRESS_HIGH: prdata = {48'h0, press_high_reg};
            default:                 prdata = '0;
        endcase
    end

    // unpack calibration words
    always_comb
    begin
        cal.t1 = temp_calib_reg[15:0];
        cal.t2 = temp_calib_reg[31:16];
        cal.t3 = temp_calib_reg[47:32];
        cal.p1 = press_low_reg[15:0];
        cal.p2 = press_low_reg[31:16];
        cal.p3 = press_low_reg[47:32];
        cal.p4 = press_low_reg[63:48];
        cal.p5 = press_mid_reg[15:0];
        cal.p6 = press_mid_reg[31:16];
        cal.p7 = press_mid_reg[47:32];
        cal.p8 = press_mid_reg[63:48];
        cal.p9 = press_high_reg;
    end

    // front end: temperature, fine temperature, numerator and divisor
    btc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .adc_temp  (s_tdata[19:0]),
        .adc_press (s_tdata[39:20]),
        .job_valid (fr_valid),
        .job       (fr_job),
        .job_full  (q_full)
    );

    assign q_push = fr_valid && !q_full;

    btc_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (fr_job),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_job),
        .empty   (q_empty)
    );

    // back end: division and pressure correction
    btc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cal         (cal),
        .job_avail   (!q_empty),
        .job         (q_job),
        .job_pop     (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .temp_centi  (temp_centi),
        .press_q24_8 (press_q24_8),
        .press_valid (press_valid)
    );

    assign m_tdata = {press_q24_8, temp_centi};
    assign m_tuser = press_valid;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for baro_temp_compensation, sample pairs in, readings out.
// Depends on btc_pkg (register indexes) and the baro_temp_compensation RTL.
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 20000;
    localparam int RAND_PER_SET = 190;
    localparam int NUM_SETS     = 6;

    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic        press_valid;
    } reading_t;

    typedef struct {
        logic        load_typ;   // write the typical calibration set before this row
        logic [19:0] adc_temp;
        logic [19:0] adc_press;
        logic        typed;      // reading given below, else taken from the predictor
        reading_t    want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // [19:0] adc_temp, [39:20] adc_press
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;     // [31:0] temp_centi, [63:32] press_q24_8
    logic [0:0]  m_tuser;     // [0] press_valid
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // shadow of the calibration registers
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_mid;
    logic [15:0] cal_press_high;

    reading_t pending_readings[$];
    int       mismatches;
    int       idle_cycles;
    logic     quiet;          // no idling on either side

    baro_temp_compensation i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Integer compensation, 64-bit wrapping, arithmetic shifts, truncating divide.
    function automatic reading_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
        longint   a_t, a_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint   ta, tb, dt, fine, x, y, p, num, u, v;
        reading_t r;
        a_t = adc_t;
        a_p = adc_p;
        t1 = cal_temp[15:0];
        t2 = $signed(cal_temp[31:16]);
        t3 = $signed(cal_temp[47:32]);
        p1 = cal_press_low[15:0];
        p2 = $signed(cal_press_low[31:16]);
        p3 = $signed(cal_press_low[47:32]);
        p4 = $signed(cal_press_low[63:48]);
        p5 = $signed(cal_press_mid[15:0]);
        p6 = $signed(cal_press_mid[31:16]);
        p7 = $signed(cal_press_mid[47:32]);
        p8 = $signed(cal_press_mid[63:48]);
        p9 = $signed(cal_press_high);

        ta = (((a_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        dt = (a_t >>> 4) - t1;
        tb = (((dt * dt) >>> 12) * t3) >>> 14;
        fine = ta + tb;
        r.temp_centi = 32'((fine * 5 + 128) >>> 8);

        x = fine - 128000;
        y = x * x * p6;
        y = y + ((x * p5) <<< 17);
        y = y + (p4 <<< 35);
        x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
        x = (64'sh0000_8000_0000_0000 + x) * p1;
        x = x >>> 33;
        r.press_q24_8 = '0;
        r.press_valid = 1'b0;
        if (x != 0)
        begin
            p = 1048576 - a_p;
            num = ((p <<< 31) - y) * 3125;
            // most negative over -1 wraps to itself
            if (num == 64'sh8000_0000_0000_0000 && x == -1)
                p = num;
            else
                p = num / x;
            u = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v = (p8 * p) >>> 19;
            p = ((p + u + v) >>> 8) + (p7 <<< 4);
            r.press_q24_8 = p[31:0];
            r.press_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            btc_pkg::REG_TEMP_CALIB: cal_temp       = value[47:0];
            btc_pkg::REG_PRESS_LOW:  cal_press_low  = value;
            btc_pkg::REG_PRESS_MID:  cal_press_mid  = value;
            default:                 cal_press_high = value[15:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_calib(input logic [47:0] tc, input logic [63:0] pl,
                              input logic [63:0] pm, input logic [15:0] ph);
        reg_write(btc_pkg::REG_TEMP_CALIB, {16'hdead, tc});   // bits above 48 are ignored
        reg_write(btc_pkg::REG_PRESS_LOW, pl);
        reg_write(btc_pkg::REG_PRESS_MID, pm);
        reg_write(btc_pkg::REG_PRESS_HIGH, {48'hbeef_0000_0000, ph});
    endtask

    // hold the sender until every reading is back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_readings.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pair(input logic [19:0] adc_t, input logic [19:0] adc_p,
                             input logic typed, input reading_t want);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {adc_p, adc_t};
        do
            @(posedge clk);
        while (!s_tready);
        pending_readings.push_back(typed ? want : compensate(adc_t, adc_p));
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [19:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return 20'h00000;
            1:       return 20'hfffff;
            2:       return 20'h7ee00 + 20'($urandom_range(0, 16'hffff));   // near room values
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word(input int kind);
        case (kind)
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver stalls in bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    // compare each reading with the oldest prediction
    always @(posedge clk)
    begin
        reading_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading %h / %b", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                w = pending_readings.pop_front();
                if (m_tdata[31:0] !== w.temp_centi)
                begin
                    $error("temp_centi: expected %0d, got %0d",
                           $signed(w.temp_centi), $signed(m_tdata[31:0]));
                    mismatches++;
                end
                if (m_tdata[63:32] !== w.press_q24_8)
                begin
                    $error("press_q24_8: expected %h, got %h", w.press_q24_8, m_tdata[63:32]);
                    mismatches++;
                end
                if (m_tuser[0] !== w.press_valid)
                begin
                    $error("press_valid: expected %b, got %b", w.press_valid, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles in which neither side nor the register port moves anything
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("baro_temp_compensation regression: fail");
            $finish;
        end
    end

    initial
    begin
        row_t     rows[$];
        reading_t zero_reading;
        row_t     rw;
        int       set_no;
        int       n;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        quiet      = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        cal_temp = '0;
        cal_press_low = '0;
        cal_press_mid = '0;
        cal_press_high = '0;
        zero_reading = '{32'd0, 32'd0, 1'b0};

        // With all-zero calibration the fine temperature is 0 and the divisor
        // is 0: every reading is 0 degC, pressure 0, flag low.
        rows.push_back('{1'b0, 20'h00000, 20'h00000, 1'b1, zero_reading});
        rows.push_back('{1'b0, 20'hfffff, 20'hfffff, 1'b1, zero_reading});
        rows.push_back('{1'b0, 20'h00000, 20'hfffff, 1'b1, zero_reading});
        rows.push_back('{1'b0, 20'hfffff, 20'h00000, 1'b1, zero_reading});
        rows.push_back('{1'b0, 20'h80000, 20'h55555, 1'b1, zero_reading});
        rows.push_back('{1'b0, 20'h7ffff, 20'haaaaa, 1'b1, zero_reading});
        // typical part, typical and extreme codes
        rows.push_back('{1'b1, 20'd519888, 20'd415148, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'h00000, 20'h00000, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'hfffff, 20'hfffff, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'h00000, 20'hfffff, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'hfffff, 20'h00000, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'h80000, 20'h80000, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'h55555, 20'haaaaa, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'haaaaa, 20'h55555, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'd519888, 20'h00001, 1'b0, zero_reading});
        rows.push_back('{1'b0, 20'd440000, 20'd300000, 1'b0, zero_reading});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.load_typ)
            begin
                drain();
                load_calib({16'hfc18, 16'h6743, 16'd27504},
                           {16'd2855, 16'd3024, 16'hd643, 16'd36477},
                           {16'hc6f8, 16'd15500, 16'hfff9, 16'd140}, 16'd6000);
            end
            send_pair(rw.adc_temp, rw.adc_press, rw.typed, rw.want);
        end

        // sender waits out every reading before the calibration changes
        for (set_no = 0; set_no < NUM_SETS; set_no++)
        begin
            drain();
            case (set_no)
                0: load_calib({16'hfc18, 16'h6743, 16'd27504},
                              {16'd2855, 16'd3024, 16'hd643, 16'd36477},
                              {16'hc6f8, 16'd15500, 16'hfff9, 16'd140}, 16'd6000);
                1: load_calib({16'h7fff, 16'h7fff, 16'hffff},
                              {4{16'h7fff}} | 64'hffff, {4{16'h7fff}}, 16'h7fff);
                2: load_calib({16'h8000, 16'h8000, 16'h0000},
                              {{3{16'h8000}}, 16'h0001}, {4{16'h8000}}, 16'h8000);
                3: load_calib({pick_word(3), pick_word(3), pick_word(3)},
                              {pick_word(3), pick_word(3), pick_word(3), 16'h0000},
                              {pick_word(3), pick_word(3), pick_word(3), pick_word(3)},
                              pick_word(3));   // P1 zero: divisor always zero
                default:
                    load_calib({pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5)),
                                pick_word($urandom_range(0, 5))},
                               {pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5)),
                                pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5))},
                               {pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5)),
                                pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5))},
                               pick_word($urandom_range(0, 5)));
            endcase
            if (set_no == NUM_SETS - 1)
                quiet = 1'b1;
            for (n = 0; n < RAND_PER_SET; n++)
                send_pair(pick_code(), pick_code(), 1'b0, zero_reading);
        end

        drain();
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("baro_temp_compensation regression: pass");
        else
            $display("baro_temp_compensation regression: fail");
        $finish;
    end

endmodule
